[sv/mtq_pkg.sv]
`default_nettype none

package mtq_pkg;

  // Quaternion component slots, in output order
  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z,
    COMP_W
  } comp_e;

  localparam int ELEM_W = 16;
  localparam int MAG_W  = 17;   // magnitude of a sum or difference of two elements
  localparam int QUO_W  = 17;   // quotient bits kept by the dividers
  localparam int LANES  = 3;

  localparam logic [ELEM_W-1:0] Q_MAX = 16'h7FFF;
  localparam logic [ELEM_W-1:0] Q_MIN = 16'h8000;

  // Per-item control that travels alongside the arithmetic
  typedef struct packed {
    logic       refl;     // determinant not positive
    comp_e      lead;     // component taken from the square root
    comp_e      dst0;     // destination of divider lane 0
    comp_e      dst1;     // destination of divider lane 1
    comp_e      dst2;     // destination of divider lane 2
    logic [2:0] neg;      // numerator sign per lane
  } ctrl_t;

  // Saturate a signed quotient given as magnitude, overflow and sign
  function automatic logic [ELEM_W-1:0] sat_lane(logic [QUO_W-1:0] mag, logic ovf, logic neg);
    logic [QUO_W-1:0] negv;
    negv = '0 - mag;
    if (!neg) begin
      sat_lane = (ovf || (mag > QUO_W'(Q_MAX))) ? Q_MAX : mag[ELEM_W-1:0];
    end else begin
      sat_lane = (ovf || (mag > QUO_W'(Q_MIN))) ? Q_MIN : negv[ELEM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[sv/mtq_front.sv]
`default_nettype none

// Front end: minors, trace, axis pick, radicand and numerators, then the
// determinant sign over two more stages.
module mtq_front #(
  parameter int FRAC_BITS = 14,
  localparam int TW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2,
  localparam int RW    = TW - 1 + FRAC_BITS,
  localparam int SW    = (RW + 1) / 2,
  localparam int RAD_W = 2 * SW
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      vld_i,
  input  logic [8:0][mtq_pkg::ELEM_W-1:0]           elem_i,
  output logic                                      vld_o,
  output logic [RAD_W-1:0]                          rad_o,
  output logic [2:0][mtq_pkg::MAG_W-1:0]            mag_o,
  output mtq_pkg::ctrl_t                            ctrl_o
);
  import mtq_pkg::*;

  localparam logic signed [TW-1:0] ONE_T =
    {{(TW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  assign a00 = elem_i[0];
  assign a01 = elem_i[1];
  assign a02 = elem_i[2];
  assign a10 = elem_i[3];
  assign a11 = elem_i[4];
  assign a12 = elem_i[5];
  assign a20 = elem_i[6];
  assign a21 = elem_i[7];
  assign a22 = elem_i[8];

  // Stage 1 logic
  logic signed [TW-1:0]   tr, tn, tsel;
  logic                   tr_pos;
  comp_e                  ax;
  logic signed [15:0]     dmax, dii, djj, dkk;
  logic signed [31:0]     p11, p12, p10, p13, p14, p15;
  logic signed [32:0]     m0_d, m1_d, m2_d;
  logic [RAD_W-1:0]       rad_d;
  logic signed [16:0]     n [3];
  logic [2:0][MAG_W-1:0]  mag_d;
  ctrl_t                  ctrl_d;

  // Cofactor minors of row 0
  always_comb begin
    p11  = a11 * a22;
    p12  = a12 * a21;
    p10  = a10 * a22;
    p13  = a12 * a20;
    p14  = a10 * a21;
    p15  = a11 * a20;
    m0_d = 33'(p11) - 33'(p12);
    m1_d = 33'(p10) - 33'(p13);
    m2_d = 33'(p14) - 33'(p15);
  end

  // Branch, axis and radicand
  always_comb begin
    tr     = TW'(a00) + TW'(a11) + TW'(a22);
    tr_pos = !tr[TW-1] && (tr != '0);
    ax     = COMP_X;
    dmax   = a00;
    if (a11 > a00) begin
      ax   = COMP_Y;
      dmax = a11;
    end
    if (a22 > dmax) begin
      ax = COMP_Z;
    end
    case (ax)
      COMP_Y: begin
        dii = a11; djj = a22; dkk = a00;
      end
      COMP_Z: begin
        dii = a22; djj = a00; dkk = a11;
      end
      default: begin
        dii = a00; djj = a11; dkk = a22;
      end
    endcase
    tn = ONE_T + TW'(dii) - TW'(djj) - TW'(dkk);
    if (tn[TW-1] || (tn == '0)) begin
      tn = TW'(1);
    end
    tsel  = tr_pos ? (tr + ONE_T) : tn;
    rad_d = RAD_W'({tsel[TW-2:0], {FRAC_BITS{1'b0}}});
  end

  // Numerators and their lane destinations
  always_comb begin
    ctrl_d.refl = 1'b0;
    if (tr_pos) begin
      ctrl_d.lead = COMP_W;
      ctrl_d.dst0 = COMP_X; n[0] = 17'(a21) - 17'(a12);
      ctrl_d.dst1 = COMP_Y; n[1] = 17'(a02) - 17'(a20);
      ctrl_d.dst2 = COMP_Z; n[2] = 17'(a10) - 17'(a01);
    end else begin
      case (ax)
        COMP_Y: begin
          ctrl_d.lead = COMP_Y;
          ctrl_d.dst0 = COMP_W; n[0] = 17'(a02) - 17'(a20);
          ctrl_d.dst1 = COMP_Z; n[1] = 17'(a21) + 17'(a12);
          ctrl_d.dst2 = COMP_X; n[2] = 17'(a01) + 17'(a10);
        end
        COMP_Z: begin
          ctrl_d.lead = COMP_Z;
          ctrl_d.dst0 = COMP_W; n[0] = 17'(a10) - 17'(a01);
          ctrl_d.dst1 = COMP_X; n[1] = 17'(a02) + 17'(a20);
          ctrl_d.dst2 = COMP_Y; n[2] = 17'(a12) + 17'(a21);
        end
        default: begin
          ctrl_d.lead = COMP_X;
          ctrl_d.dst0 = COMP_W; n[0] = 17'(a21) - 17'(a12);
          ctrl_d.dst1 = COMP_Y; n[1] = 17'(a10) + 17'(a01);
          ctrl_d.dst2 = COMP_Z; n[2] = 17'(a20) + 17'(a02);
        end
      endcase
    end
    for (int l = 0; l < LANES; l++) begin
      ctrl_d.neg[l] = n[l][16];
      mag_d[l]      = n[l][16] ? MAG_W'(-n[l]) : MAG_W'(n[l]);
    end
  end

  // Stage registers
  logic                  s1_vld_q, s2_vld_q, s3_vld_q;
  logic signed [15:0]    s1_a00_q, s1_a01_q, s1_a02_q;
  logic signed [32:0]    s1_m0_q, s1_m1_q, s1_m2_q;
  logic signed [48:0]    s2_p0_q, s2_p1_q, s2_p2_q;
  logic signed [48:0]    s2_p0_d, s2_p1_d, s2_p2_d;
  logic signed [50:0]    det;
  logic [RAD_W-1:0]      s1_rad_q, s2_rad_q, s3_rad_q;
  logic [2:0][MAG_W-1:0] s1_mag_q, s2_mag_q, s3_mag_q;
  ctrl_t                 s1_ctrl_q, s2_ctrl_q, s3_ctrl_q, s3_ctrl_d;

  // Determinant products and sum
  always_comb begin
    s2_p0_d = s1_a00_q * s1_m0_q;
    s2_p1_d = s1_a01_q * s1_m1_q;
    s2_p2_d = s1_a02_q * s1_m2_q;
    det     = 51'(s2_p0_q) - 51'(s2_p1_q) + 51'(s2_p2_q);
    s3_ctrl_d      = s2_ctrl_q;
    s3_ctrl_d.refl = det[50] || (det == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_a00_q  <= a00;
      s1_a01_q  <= a01;
      s1_a02_q  <= a02;
      s1_m0_q   <= m0_d;
      s1_m1_q   <= m1_d;
      s1_m2_q   <= m2_d;
      s1_rad_q  <= rad_d;
      s1_mag_q  <= mag_d;
      s1_ctrl_q <= ctrl_d;
      s2_p0_q   <= s2_p0_d;
      s2_p1_q   <= s2_p1_d;
      s2_p2_q   <= s2_p2_d;
      s2_rad_q  <= s1_rad_q;
      s2_mag_q  <= s1_mag_q;
      s2_ctrl_q <= s1_ctrl_q;
      s3_rad_q  <= s2_rad_q;
      s3_mag_q  <= s2_mag_q;
      s3_ctrl_q <= s3_ctrl_d;
    end
  end

  assign vld_o  = s3_vld_q;
  assign rad_o  = s3_rad_q;
  assign mag_o  = s3_mag_q;
  assign ctrl_o = s3_ctrl_q;

endmodule

`default_nettype wire

[sv/mtq_isqrt.sv]
`default_nettype none

// Pipelined integer square root, one root bit per stage.
module mtq_isqrt #(
  parameter int FRAC_BITS = 14,
  localparam int TW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2,
  localparam int RW    = TW - 1 + FRAC_BITS,
  localparam int SW    = (RW + 1) / 2,
  localparam int RAD_W = 2 * SW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic [RAD_W-1:0]                  rad_i,
  input  logic [2:0][mtq_pkg::MAG_W-1:0]    mag_i,
  input  mtq_pkg::ctrl_t                    ctrl_i,
  output logic                              vld_o,
  output logic [SW-1:0]                     root_o,
  output logic [2:0][mtq_pkg::MAG_W-1:0]    mag_o,
  output mtq_pkg::ctrl_t                    ctrl_o
);
  import mtq_pkg::*;

  localparam int RMW = SW + 3;

  logic                  vld_q  [SW];
  logic [RMW-1:0]        rem_q  [SW];
  logic [SW-1:0]         root_q [SW];
  logic [RAD_W-1:0]      rad_q  [SW];
  logic [2:0][MAG_W-1:0] mag_q  [SW];
  ctrl_t                 ctrl_q [SW];

  for (genvar s = 0; s < SW; s++) begin : g_stage
    logic                  v_in;
    logic [RMW-1:0]        rem_in, cur, trial;
    logic [SW-1:0]         root_in;
    logic [RAD_W-1:0]      rad_in;
    logic [2:0][MAG_W-1:0] mag_in;
    ctrl_t                 ctrl_in;

    if (s == 0) begin : g_first
      assign v_in    = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign mag_in  = mag_i;
      assign ctrl_in = ctrl_i;
    end else begin : g_next
      assign v_in    = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign mag_in  = mag_q[s-1];
      assign ctrl_in = ctrl_q[s-1];
    end

    // Bring down the next two radicand bits and try the next root bit
    always_comb begin
      cur   = {rem_in[RMW-3:0], rad_in[RAD_W-1 -: 2]};
      trial = RMW'({root_in, 2'b01});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= trial) begin
          rem_q[s]  <= cur - trial;
          root_q[s] <= {root_in[SW-2:0], 1'b1};
        end else begin
          rem_q[s]  <= cur;
          root_q[s] <= {root_in[SW-2:0], 1'b0};
        end
        rad_q[s]  <= rad_in << 2;
        mag_q[s]  <= mag_in;
        ctrl_q[s] <= ctrl_in;
      end
    end
  end

  assign vld_o  = vld_q[SW-1];
  assign root_o = root_q[SW-1];
  assign mag_o  = mag_q[SW-1];
  assign ctrl_o = ctrl_q[SW-1];

endmodule

`default_nettype wire

[sv/mtq_div.sv]
`default_nettype none

// Three restoring divider lanes, one quotient bit per stage, computing
// (mag << FRAC_BITS + r) / (2 r) with an overflow flag.
module mtq_div #(
  parameter int FRAC_BITS = 14,
  localparam int TW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2,
  localparam int RW = TW - 1 + FRAC_BITS,
  localparam int SW = (RW + 1) / 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic [SW-1:0]                     root_i,
  input  logic [2:0][mtq_pkg::MAG_W-1:0]    mag_i,
  input  mtq_pkg::ctrl_t                    ctrl_i,
  output logic                              vld_o,
  output logic [SW-1:0]                     root_o,
  output logic [2:0][mtq_pkg::QUO_W-1:0]    quo_o,
  output logic [2:0]                        ovf_o,
  output mtq_pkg::ctrl_t                    ctrl_o
);
  import mtq_pkg::*;

  localparam int NW0 = ((MAG_W + FRAC_BITS) > SW) ? (MAG_W + FRAC_BITS) : SW;
  localparam int NW  = NW0 + 1;
  localparam int CW  = (NW > (SW + 1 + QUO_W)) ? NW : (SW + 1 + QUO_W);

  // Setup stage: numerator, divisor and overflow check
  logic [2:0][CW-1:0] num_d;
  logic [2:0]         ovf_d;
  logic [CW-1:0]      lim;

  always_comb begin
    lim = CW'({root_i, 1'b0, {QUO_W{1'b0}}});
    for (int l = 0; l < LANES; l++) begin
      num_d[l] = CW'(NW'({mag_i[l], {FRAC_BITS{1'b0}}}) + NW'(root_i));
      ovf_d[l] = num_d[l] >= lim;
    end
  end

  logic               v0_q;
  logic [SW:0]        d0_q;
  logic [SW-1:0]      root0_q;
  logic [2:0][CW-1:0] rem0_q;
  logic [2:0]         ovf0_q;
  ctrl_t              ctrl0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d0_q    <= {root_i, 1'b0};
      root0_q <= root_i;
      rem0_q  <= num_d;
      ovf0_q  <= ovf_d;
      ctrl0_q <= ctrl_i;
    end
  end

  logic                  vld_q  [QUO_W];
  logic [SW:0]           d_q    [QUO_W];
  logic [SW-1:0]         root_q [QUO_W];
  logic [2:0][CW-1:0]    rem_q  [QUO_W];
  logic [2:0][QUO_W-1:0] quo_q  [QUO_W];
  logic [2:0]            ovf_q  [QUO_W];
  ctrl_t                 ctrl_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int B = QUO_W - 1 - s;

    logic                  v_in;
    logic [SW:0]           d_in;
    logic [SW-1:0]         root_in;
    logic [2:0][CW-1:0]    rem_in, rem_d;
    logic [2:0][QUO_W-1:0] quo_in;
    logic [2:0]            ovf_in, qbit;
    ctrl_t                 ctrl_in;
    logic [CW-1:0]         trial;

    if (s == 0) begin : g_first
      assign v_in    = v0_q;
      assign d_in    = d0_q;
      assign root_in = root0_q;
      assign rem_in  = rem0_q;
      assign quo_in  = '0;
      assign ovf_in  = ovf0_q;
      assign ctrl_in = ctrl0_q;
    end else begin : g_next
      assign v_in    = vld_q[s-1];
      assign d_in    = d_q[s-1];
      assign root_in = root_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign ovf_in  = ovf_q[s-1];
      assign ctrl_in = ctrl_q[s-1];
    end

    // Subtract the shifted divisor where it fits
    always_comb begin
      trial = CW'(d_in) << B;
      for (int l = 0; l < LANES; l++) begin
        qbit[l]  = rem_in[l] >= trial;
        rem_d[l] = qbit[l] ? (rem_in[l] - trial) : rem_in[l];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[s]    <= d_in;
        root_q[s] <= root_in;
        rem_q[s]  <= rem_d;
        for (int l = 0; l < LANES; l++) begin
          quo_q[s][l] <= {quo_in[l][QUO_W-2:0], qbit[l]};
        end
        ovf_q[s]  <= ovf_in;
        ctrl_q[s] <= ctrl_in;
      end
    end
  end

  assign vld_o  = vld_q[QUO_W-1];
  assign root_o = root_q[QUO_W-1];
  assign quo_o  = quo_q[QUO_W-1];
  assign ovf_o  = ovf_q[QUO_W-1];
  assign ctrl_o = ctrl_q[QUO_W-1];

endmodule

`default_nettype wire

[sv/matrix_to_quaternion.sv]
`default_nettype none

// Rotation matrix to unit quaternion converter (Shoemake). One 3x3 matrix of
// signed fixed-point elements (FRAC_BITS fraction bits, Q2.14 by default) is
// taken per cycle while s_axis_tready is high; one quaternion comes out per
// matrix, in order. The square root is SW bits wide, with SW =
// (max(FRAC_BITS,17) + FRAC_BITS + 2) / 2, and is computed bit per stage;
// the three bit-per-stage divider lanes follow it. A matrix with non-positive
// determinant gives the zero quaternion with tuser set. Components saturate
// to 16 bits. An output register plus a skid register hold finished results,
// so the input keeps taking matrices while one result waits; input ready
// drops only when both are full.
module matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // elem_00, elem_01, elem_02, elem_10, elem_11, elem_12, elem_20, elem_21, elem_22
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w
  output logic [63:0]  m_axis_tdata,
  // reflected
  output logic         m_axis_tuser
);
  import mtq_pkg::*;

  localparam int TW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int RW    = TW - 1 + FRAC_BITS;
  localparam int SW    = (RW + 1) / 2;
  localparam int RAD_W = 2 * SW;
  localparam int LW    = SW + ELEM_W;

  logic                  en;
  logic                  fr_vld, sq_vld, dv_vld;
  logic [RAD_W-1:0]      fr_rad;
  logic [2:0][MAG_W-1:0] fr_mag, sq_mag;
  ctrl_t                 fr_ctrl, sq_ctrl, dv_ctrl;
  logic [SW-1:0]         sq_root, dv_root;
  logic [2:0][QUO_W-1:0] dv_quo;
  logic [2:0]            dv_ovf;

  mtq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .elem_i (s_axis_tdata),
    .vld_o  (fr_vld),
    .rad_o  (fr_rad),
    .mag_o  (fr_mag),
    .ctrl_o (fr_ctrl)
  );

  mtq_isqrt #(.FRAC_BITS(FRAC_BITS)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fr_vld),
    .rad_i  (fr_rad),
    .mag_i  (fr_mag),
    .ctrl_i (fr_ctrl),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .mag_o  (sq_mag),
    .ctrl_o (sq_ctrl)
  );

  mtq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .root_i (sq_root),
    .mag_i  (sq_mag),
    .ctrl_i (sq_ctrl),
    .vld_o  (dv_vld),
    .root_o (dv_root),
    .quo_o  (dv_quo),
    .ovf_o  (dv_ovf),
    .ctrl_o (dv_ctrl)
  );

  // Leading component, lane saturation and slot assembly
  logic [SW:0]              lead_sum;
  logic [SW-1:0]            lead_raw;
  logic [ELEM_W-1:0]        lead_val;
  logic [3:0][ELEM_W-1:0]   comp;

  always_comb begin
    lead_sum = (SW + 1)'(dv_root) + (SW + 1)'(1);
    lead_raw = lead_sum[SW:1];
    lead_val = (LW'(lead_raw) > LW'(Q_MAX)) ? Q_MAX : ELEM_W'(lead_raw);
    comp = '0;
    comp[dv_ctrl.lead] = lead_val;
    comp[dv_ctrl.dst0] = sat_lane(dv_quo[0], dv_ovf[0], dv_ctrl.neg[0]);
    comp[dv_ctrl.dst1] = sat_lane(dv_quo[1], dv_ovf[1], dv_ctrl.neg[1]);
    comp[dv_ctrl.dst2] = sat_lane(dv_quo[2], dv_ovf[2], dv_ctrl.neg[2]);
    if (dv_ctrl.refl) begin
      comp = '0;
    end
  end

  // Output register with skid register behind it
  logic        out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic [63:0] out_data_q, skid_data_q;
  logic        out_user_q, skid_user_q;
  logic        take, load_out, load_skid, pop_skid;

  assign en = !skid_vld_q;

  always_comb begin
    take      = en && dv_vld;
    pop_skid  = skid_vld_q && m_axis_tready;
    load_out  = take && (!out_vld_q || m_axis_tready);
    load_skid = take && out_vld_q && !m_axis_tready;
    if (skid_vld_q) begin
      out_vld_d  = 1'b1;
      skid_vld_d = !m_axis_tready;
    end else begin
      out_vld_d  = take || (out_vld_q && !m_axis_tready);
      skid_vld_d = load_skid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_skid) begin
      out_data_q <= skid_data_q;
      out_user_q <= skid_user_q;
    end else if (load_out) begin
      out_data_q <= comp;
      out_user_q <= dv_ctrl.refl;
    end
    if (load_skid) begin
      skid_data_q <= comp;
      skid_user_q <= dv_ctrl.refl;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
  // A reflection result carries the zero quaternion
  a_refl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("reflected result with nonzero quaternion");

  // The skid register only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while output register empty");

  // A stalled output with a finished item arriving fills the skid register
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready && !skid_vld_q && dv_vld) |=> skid_vld_q)
    else $error("finished item not captured while output stalled");

  // Non-reflected results have a nonnegative leading component
  a_lead_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !dv_ctrl.refl) |-> !lead_val[ELEM_W-1])
    else $error("leading component negative");
`endif

endmodule

`default_nettype wire
